/* rtl/scic_pkg.sv */
// shared types, constants and the crc byte update for the snapshot image checker
`timescale 1ns / 1ps
`default_nettype none
package scic_pkg;

	localparam int unsigned HdrBytes = 16;
	localparam int unsigned CountW = 13;
	localparam int unsigned SizeW = 12;
	localparam int unsigned AddrW = 4;

	localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
	localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
	localparam logic [31:0] MagicReset = 32'hDEAD_BEEF;
	localparam logic [31:0] VersionReset = 32'h0000_0001;
	localparam logic [SizeW-1:0] SizeReset = 12'd94;
	localparam logic [CountW-1:0] CountMax = '1;

	typedef enum logic [1:0] {
		REG_MAGIC   = 2'd0,
		REG_VERSION = 2'd1,
		REG_SIZE    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		FAULT_OK      = 3'd0,
		FAULT_MAGIC   = 3'd1,
		FAULT_VERSION = 3'd2,
		FAULT_SIZE    = 3'd3,
		FAULT_CRC     = 3'd4,
		FAULT_SHORT   = 3'd5
	} fault_t;

	typedef struct packed {
		logic [31:0]      magic;
		logic [31:0]      version;
		logic [SizeW-1:0] size;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	// reflected crc-32, one byte, lsb first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = {1'b0, c[31:1]} ^ (c[0] ? CrcPoly : 32'h0);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/scic_if.sv */
// valid/ready channels for image beats and check results
`timescale 1ns / 1ps
`default_nettype none
interface scic_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface scic_result_if;
	logic        valid;
	logic        ready;
	logic        image_ok;
	logic [2:0]  fault_code;
	logic [31:0] computed_crc;

	modport source(output valid, output image_ok, output fault_code, output computed_crc,
		input ready);
	modport sink(input valid, input image_ok, input fault_code, input computed_crc,
		output ready);
endinterface
`default_nettype wire

/* rtl/scic_cfg.sv */
// apb register file: expected magic, version and payload size
`timescale 1ns / 1ps
`default_nettype none
module scic_cfg #(
	parameter int unsigned MAX_PAYLOAD_BYTES = 4080
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [scic_pkg::AddrW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output scic_pkg::cfg_t                   cfg
);

	localparam logic [16:0] MaxSize = 17'(MAX_PAYLOAD_BYTES);

	logic [31:0]                magic_q;
	logic [31:0]                version_q;
	logic [scic_pkg::SizeW-1:0] size_q;
	logic                       wr_en;
	logic [1:0]                 idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= scic_pkg::MagicReset;
			version_q <= scic_pkg::VersionReset;
			size_q    <= scic_pkg::SizeReset;
		end else if (wr_en) begin
			unique case (idx)
				scic_pkg::REG_MAGIC:   magic_q   <= pwdata;
				scic_pkg::REG_VERSION: version_q <= pwdata;
				scic_pkg::REG_SIZE:    size_q    <= pwdata[scic_pkg::SizeW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			scic_pkg::REG_MAGIC:   prdata = magic_q;
			scic_pkg::REG_VERSION: prdata = version_q;
			scic_pkg::REG_SIZE:    prdata = {{(32-scic_pkg::SizeW){1'b0}}, size_q};
			default:               prdata = 32'h0;
		endcase
	end

	// payload size clamped to the build limit
	always_comb begin
		cfg.magic   = magic_q;
		cfg.version = version_q;
		if ({5'b0, size_q} > MaxSize) begin
			cfg.size = MaxSize[scic_pkg::SizeW-1:0];
		end else begin
			cfg.size = size_q;
		end
	end

endmodule
`default_nettype wire

/* rtl/scic_in_reg.sv */
// input register stage for image beats
`timescale 1ns / 1ps
`default_nettype none
module scic_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	scic_byte_if.sink          image,
	input  wire logic          adv,
	output logic               valid_s1,
	output scic_pkg::beat_t    beat_s1
);

	assign image.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (image.ready) begin
			valid_s1 <= image.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (image.ready && image.valid) begin
			beat_s1.data_byte <= image.data_byte;
			beat_s1.last_byte <= image.last_byte;
		end
	end

endmodule
`default_nettype wire

/* rtl/scic_check.sv */
// header capture, crc update, image checks and result register
`timescale 1ns / 1ps
`default_nettype none
module scic_check (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire scic_pkg::cfg_t  cfg,
	input  wire logic            valid_s1,
	input  wire scic_pkg::beat_t beat_s1,
	output logic                 adv,
	scic_result_if.source        verdict
);

	logic [scic_pkg::CountW-1:0] count_q;
	logic [31:0]                 crc_q;
	logic [3:0][31:0]            hdr_q;
	logic                        vld_q;
	logic                        ok_q;
	scic_pkg::fault_t            fault_q;
	logic [31:0]                 crc_out_q;

	logic [scic_pkg::CountW-1:0] count_nxt;
	logic [31:0]                 crc_nxt;
	logic [3:0][31:0]            hdr_nxt;
	logic [13:0]                 end_pos;
	logic                        in_hdr;
	logic                        in_payload;
	logic [31:0]                 crc_fin;
	scic_pkg::fault_t            fault;

	assign adv = valid_s1 && (!vld_q || verdict.ready);

	assign end_pos    = 14'(scic_pkg::HdrBytes) + {2'b0, cfg.size};
	assign in_hdr     = count_q < scic_pkg::CountW'(scic_pkg::HdrBytes);
	assign in_payload = !in_hdr && ({1'b0, count_q} < end_pos);

	always_comb begin
		hdr_nxt = hdr_q;
		if (in_hdr) begin
			hdr_nxt[count_q[3:2]][{count_q[1:0], 3'b000} +: 8] = beat_s1.data_byte;
		end
		crc_nxt   = in_payload ? scic_pkg::crc_byte(crc_q, beat_s1.data_byte) : crc_q;
		count_nxt = (count_q == scic_pkg::CountMax) ? count_q : count_q + 1'b1;
		crc_fin   = ~crc_nxt;
	end

	// checks in priority order on the state after this beat
	always_comb begin
		priority if (count_nxt < scic_pkg::CountW'(scic_pkg::HdrBytes)) begin
			fault = scic_pkg::FAULT_SHORT;
		end else if (hdr_nxt[0] != cfg.magic) begin
			fault = scic_pkg::FAULT_MAGIC;
		end else if (hdr_nxt[1] != cfg.version) begin
			fault = scic_pkg::FAULT_VERSION;
		end else if (hdr_nxt[2] != {{(32-scic_pkg::SizeW){1'b0}}, cfg.size}) begin
			fault = scic_pkg::FAULT_SIZE;
		end else if ({1'b0, count_nxt} < end_pos) begin
			fault = scic_pkg::FAULT_SHORT;
		end else if (hdr_nxt[3] != crc_fin) begin
			fault = scic_pkg::FAULT_CRC;
		end else begin
			fault = scic_pkg::FAULT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= scic_pkg::CrcInit;
			hdr_q   <= '0;
		end else if (adv) begin
			if (beat_s1.last_byte) begin
				count_q <= '0;
				crc_q   <= scic_pkg::CrcInit;
				hdr_q   <= '0;
			end else begin
				count_q <= count_nxt;
				crc_q   <= crc_nxt;
				hdr_q   <= hdr_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv && beat_s1.last_byte) begin
			vld_q <= 1'b1;
		end else if (verdict.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && beat_s1.last_byte) begin
			ok_q      <= (fault == scic_pkg::FAULT_OK);
			fault_q   <= fault;
			crc_out_q <= crc_fin;
		end
	end

	assign verdict.valid        = vld_q;
	assign verdict.image_ok     = ok_q;
	assign verdict.fault_code   = fault_q;
	assign verdict.computed_crc = crc_out_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && beat_s1.last_byte && vld_q && !verdict.ready))
		else $error("result overwritten while stalled");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && beat_s1.last_byte) |=> (count_q == '0 && crc_q == scic_pkg::CrcInit))
		else $error("image state not cleared after last beat");

	a_ok_matches_fault: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (ok_q == (fault_q == scic_pkg::FAULT_OK)))
		else $error("image_ok disagrees with fault_code");

	a_short_before_header: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && beat_s1.last_byte && count_q < 13'd15) |=> (fault_q == scic_pkg::FAULT_SHORT))
		else $error("short image not flagged");
`endif

endmodule
`default_nettype wire

/* rtl/snapshot_image_crc_checker.sv */
// Snapshot image checker top level.
// An image enters on the image channel one byte per beat, last_byte set on the
// final beat. The first 16 bytes are the header words (magic, version, size,
// stored crc, little-endian); the payload follows and is run through a
// reflected crc-32. One result leaves on the verdict channel per image, on the
// last beat: image_ok, fault_code and the computed crc.
// Expected magic, version and payload size sit in an apb register file at
// byte offsets 0, 4 and 8; write them only while no image is in flight.
// Throughput is one byte per cycle unless a pending result stalls: the crc
// byte update is unrolled into the single logic stage between the input
// register and the result register, which a last beat passes in that order.
// While a result waits with verdict.ready low it holds and the pipeline
// stalls, with image.ready dropping once the input register is also full.
// Reset returns the registers to their defaults and clears the image state;
// after each last beat the image state clears again for the next image.
`timescale 1ns / 1ps
`default_nettype none
module snapshot_image_crc_checker #(
	parameter int unsigned MAX_PAYLOAD_BYTES = 4080
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [scic_pkg::AddrW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	scic_byte_if.sink                        image,
	scic_result_if.source                    verdict
);

	scic_pkg::cfg_t  cfg;
	scic_pkg::beat_t beat_s1;
	logic            valid_s1;
	logic            adv;

	scic_cfg #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scic_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.image    (image),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	scic_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.adv      (adv),
		.verdict  (verdict)
	);

endmodule
`default_nettype wire

/* tb/tb_snapshot_image_crc_checker.sv */
// testbench for the snapshot image crc checker: apb setup, image beats and verdict scoreboard
`timescale 1ns / 1ps
module tb_snapshot_image_crc_checker;

	localparam int unsigned MaxPayload = 4080;
	localparam logic [31:0] ReflPoly = 32'hEDB8_8320;
	localparam logic [scic_pkg::CountW-1:0] BeatCountMax = 13'h1FFF;
	localparam int unsigned RandomBeats = 1100;
	localparam int unsigned MaxShown = 10;
	localparam logic [scic_pkg::AddrW-1:0] AddrUnmapped = 4'd12;

	typedef enum int {
		IMG_GOOD,
		IMG_BAD_MAGIC,
		IMG_BAD_VERSION,
		IMG_BAD_SIZE,
		IMG_BAD_CRC,
		IMG_SHORT_HDR,
		IMG_SHORT_PAYLOAD,
		IMG_NOISE
	} image_kind_t;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	typedef struct packed {
		logic             ok;
		scic_pkg::fault_t fault;
		logic [31:0]      crc;
	} verdict_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [scic_pkg::AddrW-1:0]  paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	scic_byte_if   img_bus();
	scic_result_if res_bus();

	snapshot_image_crc_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.image(img_bus),
		.verdict(res_bus)
	);

	always #5 clk = ~clk;

	// register mirror
	logic [31:0]                cfg_magic;
	logic [31:0]                cfg_version;
	logic [scic_pkg::SizeW-1:0] cfg_size;

	// image state of the predictor
	logic [scic_pkg::CountW-1:0] img_count;
	logic [31:0]                 crc_run;
	logic [31:0]                 hdr_word [4];

	verdict_t    expected_verdicts[$];
	logic [7:0]  image_bytes[$];
	int unsigned beats_sent;
	int unsigned mismatches;
	bit          quiet;

	function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ ReflPoly;
			end
		end
		return c;
	endfunction

	function automatic int unsigned eff_size();
		return (cfg_size > MaxPayload) ? MaxPayload : cfg_size;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= MaxShown) begin
			$display("mismatch: %s", msg);
		end
	endtask

	task automatic clear_image();
		img_count = '0;
		crc_run = '1;
		for (int i = 0; i < 4; i++) begin
			hdr_word[i] = '0;
		end
	endtask

	task automatic predict_beat(input logic [7:0] d, input logic l);
		verdict_t v;
		int unsigned size;
		logic [31:0] crc_out;
		size = eff_size();
		if (img_count < scic_pkg::HdrBytes) begin
			hdr_word[img_count[3:2]][8*img_count[1:0] +: 8] = d;
		end else if (img_count < scic_pkg::HdrBytes + size) begin
			crc_run = crc_update(crc_run, d);
		end
		if (img_count != BeatCountMax) begin
			img_count++;
		end
		if (l) begin
			crc_out = ~crc_run;
			if (img_count < scic_pkg::HdrBytes) begin
				v.fault = scic_pkg::FAULT_SHORT;
			end else if (hdr_word[0] != cfg_magic) begin
				v.fault = scic_pkg::FAULT_MAGIC;
			end else if (hdr_word[1] != cfg_version) begin
				v.fault = scic_pkg::FAULT_VERSION;
			end else if (hdr_word[2] != size) begin
				v.fault = scic_pkg::FAULT_SIZE;
			end else if (img_count < scic_pkg::HdrBytes + size) begin
				v.fault = scic_pkg::FAULT_SHORT;
			end else if (hdr_word[3] != crc_out) begin
				v.fault = scic_pkg::FAULT_CRC;
			end else begin
				v.fault = scic_pkg::FAULT_OK;
			end
			v.ok = (v.fault == scic_pkg::FAULT_OK);
			v.crc = crc_out;
			expected_verdicts.push_back(v);
			clear_image();
		end
	endtask

	// called at a rising edge; returns at the edge that takes the beat
	task automatic send_beat(input logic [7:0] d, input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			img_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		img_bus.valid <= 1'b1;
		img_bus.data_byte <= d;
		img_bus.last_byte <= l;
		@(posedge clk);
		while (!img_bus.ready) @(posedge clk);
		predict_beat(d, l);
		beats_sent++;
	endtask

	task automatic send_image();
		int unsigned n;
		n = image_bytes.size();
		for (int unsigned i = 0; i < n; i++) begin
			send_beat(image_bytes[i], i == n - 1);
		end
	endtask

	task automatic trim_image(input int unsigned n);
		while (image_bytes.size() > n) void'(image_bytes.pop_back());
	endtask

	// header from the current register values, then payload, then optional trailing bytes
	task automatic make_image(input image_kind_t kind, input fill_t fill, input int unsigned extra);
		logic [31:0] words [4];
		logic [7:0] payload[$];
		logic [7:0] b;
		logic [31:0] crc;
		int unsigned size;
		int unsigned k;
		size = eff_size();
		crc = '1;
		for (int unsigned i = 0; i < size; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			payload.push_back(b);
			crc = crc_update(crc, b);
		end
		words[0] = cfg_magic;
		words[1] = cfg_version;
		words[2] = size;
		words[3] = ~crc;
		k = $urandom_range(0, 31);
		case (kind)
			IMG_BAD_MAGIC: words[0][k] = ~words[0][k];
			IMG_BAD_VERSION: words[1][k] = ~words[1][k];
			IMG_BAD_SIZE: words[2][k] = ~words[2][k];
			IMG_BAD_CRC: words[3][k] = ~words[3][k];
			default: ;
		endcase
		image_bytes.delete();
		for (int w = 0; w < 4; w++) begin
			for (int j = 0; j < 4; j++) begin
				image_bytes.push_back(words[w][8*j +: 8]);
			end
		end
		foreach (payload[i]) image_bytes.push_back(payload[i]);
		repeat (extra) image_bytes.push_back(8'($urandom_range(0, 255)));
		case (kind)
			IMG_SHORT_HDR: trim_image($urandom_range(1, 15));
			IMG_SHORT_PAYLOAD: begin
				if (size > 0) begin
					trim_image(scic_pkg::HdrBytes + $urandom_range(0, size - 1));
				end
			end
			IMG_NOISE: begin
				image_bytes.delete();
				repeat ($urandom_range(1, 40)) image_bytes.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		img_bus.valid <= 1'b0;
		while (expected_verdicts.size() > 0) @(posedge clk);
		// beats past the last verdict may still be in the pipeline
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [scic_pkg::AddrW-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_reg(input scic_pkg::reg_idx_t idx, input logic [31:0] value);
		apb_write({idx, 2'b00}, value);
		case (idx)
			scic_pkg::REG_MAGIC: cfg_magic = value;
			scic_pkg::REG_VERSION: cfg_version = value;
			scic_pkg::REG_SIZE: cfg_size = value[scic_pkg::SizeW-1:0];
			default: ;
		endcase
	endtask

	task automatic apb_check(input scic_pkg::reg_idx_t idx);
		logic [31:0] want;
		logic [31:0] got;
		case (idx)
			scic_pkg::REG_MAGIC: want = cfg_magic;
			scic_pkg::REG_VERSION: want = cfg_version;
			default: want = {{(32-scic_pkg::SizeW){1'b0}}, cfg_size};
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			flag($sformatf("register %s read exp %h got %h", idx.name(), want, got));
		end
		@(posedge clk);
	endtask

	task automatic check_all_regs();
		apb_check(scic_pkg::REG_MAGIC);
		apb_check(scic_pkg::REG_VERSION);
		apb_check(scic_pkg::REG_SIZE);
	endtask

	task automatic test_reset_values();
		check_all_regs();
		make_image(IMG_GOOD, FILL_RANDOM, 0);
		send_image();
		make_image(IMG_BAD_CRC, FILL_RANDOM, 0);
		send_image();
		wait_idle();
	endtask

	task automatic test_register_file();
		set_reg(scic_pkg::REG_MAGIC, 32'h0000_0000);
		set_reg(scic_pkg::REG_VERSION, 32'hFFFF_FFFF);
		set_reg(scic_pkg::REG_SIZE, 32'h0000_0000);
		check_all_regs();
		set_reg(scic_pkg::REG_MAGIC, 32'hFFFF_FFFF);
		set_reg(scic_pkg::REG_VERSION, 32'h0000_0000);
		// upper bits fall away on the narrow size register
		set_reg(scic_pkg::REG_SIZE, 32'hFFFF_FFFF);
		check_all_regs();
		apb_write(AddrUnmapped, $urandom());
		check_all_regs();
	endtask

	task automatic test_fault_order();
		set_reg(scic_pkg::REG_MAGIC, 32'h0000_0000);
		set_reg(scic_pkg::REG_VERSION, 32'hFFFF_FFFF);
		set_reg(scic_pkg::REG_SIZE, 32'd4);
		make_image(IMG_GOOD, FILL_RANDOM, 0);
		send_image();
		make_image(IMG_GOOD, FILL_ZERO, 0);
		send_image();
		make_image(IMG_GOOD, FILL_ONES, 0);
		send_image();
		make_image(IMG_BAD_MAGIC, FILL_RANDOM, 0);
		send_image();
		make_image(IMG_BAD_VERSION, FILL_RANDOM, 0);
		send_image();
		make_image(IMG_BAD_SIZE, FILL_RANDOM, 0);
		send_image();
		make_image(IMG_BAD_CRC, FILL_RANDOM, 0);
		send_image();
		// magic wins over version
		make_image(IMG_BAD_VERSION, FILL_RANDOM, 0);
		image_bytes[0] = image_bytes[0] ^ 8'h01;
		send_image();
		// size wins over a missing payload
		make_image(IMG_BAD_SIZE, FILL_RANDOM, 0);
		trim_image(18);
		send_image();
		// missing payload wins over crc
		make_image(IMG_SHORT_PAYLOAD, FILL_RANDOM, 0);
		image_bytes[12] = image_bytes[12] ^ 8'h80;
		send_image();
		make_image(IMG_GOOD, FILL_RANDOM, 0);
		trim_image(1);
		send_image();
		make_image(IMG_GOOD, FILL_RANDOM, 0);
		trim_image(15);
		send_image();
		make_image(IMG_GOOD, FILL_RANDOM, 5);
		send_image();
		wait_idle();
	endtask

	task automatic test_empty_and_single();
		set_reg(scic_pkg::REG_MAGIC, scic_pkg::MagicReset);
		set_reg(scic_pkg::REG_VERSION, scic_pkg::VersionReset);
		set_reg(scic_pkg::REG_SIZE, 32'd0);
		// empty payload: stored crc is zero
		make_image(IMG_GOOD, FILL_RANDOM, 0);
		send_image();
		make_image(IMG_GOOD, FILL_RANDOM, 3);
		send_image();
		make_image(IMG_BAD_CRC, FILL_RANDOM, 0);
		send_image();
		make_image(IMG_SHORT_HDR, FILL_RANDOM, 0);
		send_image();
		wait_idle();
		set_reg(scic_pkg::REG_SIZE, 32'd1);
		make_image(IMG_GOOD, FILL_ZERO, 0);
		send_image();
		make_image(IMG_GOOD, FILL_ONES, 0);
		send_image();
		make_image(IMG_SHORT_PAYLOAD, FILL_RANDOM, 0);
		send_image();
		wait_idle();
	endtask

	task automatic test_size_extremes();
		quiet = 1'b1;
		set_reg(scic_pkg::REG_SIZE, MaxPayload);
		// largest payload, header matches, image ends early
		make_image(IMG_GOOD, FILL_RANDOM, 0);
		trim_image(40);
		send_image();
		wait_idle();
		// clamped: the header must carry the clamped size
		set_reg(scic_pkg::REG_SIZE, 32'hFFF);
		make_image(IMG_GOOD, FILL_RANDOM, 0);
		trim_image(40);
		send_image();
		make_image(IMG_GOOD, FILL_RANDOM, 0);
		image_bytes[8] = 8'hFF;
		image_bytes[9] = 8'h0F;
		trim_image(20);
		send_image();
		wait_idle();
		quiet = 1'b0;
	endtask

	task automatic random_config();
		logic [31:0] magic;
		logic [31:0] version;
		int r;
		case ($urandom_range(0, 9))
			0: magic = 32'h0;
			1: magic = 32'hFFFF_FFFF;
			default: magic = $urandom();
		endcase
		case ($urandom_range(0, 9))
			0: version = 32'h0;
			1: version = 32'hFFFF_FFFF;
			2: version = scic_pkg::VersionReset;
			default: version = $urandom();
		endcase
		set_reg(scic_pkg::REG_MAGIC, magic);
		set_reg(scic_pkg::REG_VERSION, version);
		r = $urandom_range(0, 99);
		if (r < 70) begin
			set_reg(scic_pkg::REG_SIZE, $urandom_range(0, 24));
		end else if (r < 90) begin
			set_reg(scic_pkg::REG_SIZE, $urandom_range(25, 160));
		end else begin
			set_reg(scic_pkg::REG_SIZE, $urandom_range(0, 1));
		end
	endtask

	task automatic test_random_images();
		int unsigned phase_end;
		image_kind_t kind;
		fill_t fill;
		int unsigned extra;
		int r;
		beats_sent = 0;
		while (beats_sent < RandomBeats) begin
			random_config();
			quiet = ($urandom_range(0, 3) == 0);
			phase_end = beats_sent + $urandom_range(150, 400);
			while (beats_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 55) kind = IMG_GOOD;
				else if (r < 61) kind = IMG_BAD_MAGIC;
				else if (r < 67) kind = IMG_BAD_VERSION;
				else if (r < 73) kind = IMG_BAD_SIZE;
				else if (r < 81) kind = IMG_BAD_CRC;
				else if (r < 87) kind = IMG_SHORT_HDR;
				else if (r < 93) kind = IMG_SHORT_PAYLOAD;
				else kind = IMG_NOISE;
				r = $urandom_range(0, 9);
				fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM;
				extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
				make_image(kind, fill, extra);
				send_image();
				// now and then the sender holds off until every verdict is back
				if ($urandom_range(0, 19) == 0) begin
					wait_idle();
				end
			end
			wait_idle();
		end
		quiet = 1'b0;
	endtask

	// verdict channel backpressure
	initial begin
		int gap;
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				res_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_verdicts.size() == 0) begin
				flag($sformatf("verdict with none pending: ok %b fault %0d crc %h",
					res_bus.image_ok, res_bus.fault_code, res_bus.computed_crc));
			end else begin
				v = expected_verdicts.pop_front();
				if (res_bus.image_ok !== v.ok) begin
					flag($sformatf("image_ok exp %b got %b", v.ok, res_bus.image_ok));
				end
				if (res_bus.fault_code !== v.fault) begin
					flag($sformatf("fault_code exp %0d got %0d", v.fault, res_bus.fault_code));
				end
				if (res_bus.computed_crc !== v.crc) begin
					flag($sformatf("computed_crc exp %h got %h", v.crc, res_bus.computed_crc));
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("[snapshot_image_crc_checker] ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		img_bus.valid <= 1'b0;
		img_bus.data_byte <= '0;
		img_bus.last_byte <= 1'b0;
		mismatches = 0;
		beats_sent = 0;
		quiet = 1'b0;
		cfg_magic = scic_pkg::MagicReset;
		cfg_version = scic_pkg::VersionReset;
		cfg_size = scic_pkg::SizeReset;
		clear_image();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_register_file();
		test_fault_order();
		test_empty_and_single();
		test_size_extremes();
		test_random_images();
		wait_idle();
		if (mismatches == 0 && expected_verdicts.size() == 0) begin
			$display("[snapshot_image_crc_checker] OK");
		end else begin
			$display("[snapshot_image_crc_checker] ERROR");
		end
		$finish;
	end

endmodule
